/* src/audio_compressor_gain_envelope_defines.svh */
// assertion macros for the compressor gain envelope block
// expects clk and rst_n in the scope where the macros are used
`ifndef AUDIO_COMPRESSOR_GAIN_ENVELOPE_DEFINES_SVH
`define AUDIO_COMPRESSOR_GAIN_ENVELOPE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ACGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ACGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/acge_pkg.sv */
// shared types, constants and register codes for the compressor gain envelope
// no dependencies
`default_nettype none

package acge_pkg;

    // sample and counter sizes
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 20;

    // register widths
    localparam int THR_BITS    = 15;
    localparam int GFLOOR_BITS = 25;
    localparam int LEN_BITS    = 20;
    localparam int STEP_BITS   = 25;
    localparam int MAKEUP_BITS = 16;
    localparam int CFG_DATA_BITS = 25;
    localparam int CFG_INDEX_BITS = 3;

    // gain in Q2.24
    localparam int GAIN_BITS = 26;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << 24;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

    // threshold compare width
    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    // product widths: p1 = |sample| * gain, split low part, then makeup
    localparam int PROD_SHIFT = 36;
    localparam int SPLIT      = 20;
    localparam int P1_BITS    = SAMPLE_BITS + GAIN_BITS;
    localparam int PA_BITS    = P1_BITS - SPLIT + MAKEUP_BITS;
    localparam int PB_BITS    = SPLIT + MAKEUP_BITS;
    localparam int SUM_BITS   = PA_BITS + 1;
    localparam int Q_BITS     = SUM_BITS - (PROD_SHIFT - SPLIT);

    // register reset values
    localparam logic [THR_BITS-1:0]    RST_THRESHOLD = 15'd32767;
    localparam logic [GFLOOR_BITS-1:0] RST_FLOOR     = 25'd16777216;
    localparam logic [LEN_BITS-1:0]    RST_ATTACK    = 20'd480;
    localparam logic [LEN_BITS-1:0]    RST_RELEASE   = 20'd4800;
    localparam logic [MAKEUP_BITS-1:0] RST_MAKEUP    = 16'd4096;

    // register index codes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD   = 3'd0,
        REG_GAIN_FLOOR  = 3'd1,
        REG_ATTACK_LEN  = 3'd2,
        REG_RELEASE_LEN = 3'd3,
        REG_ATTACK_STEP = 3'd4,
        REG_RELEASE_STEP = 3'd5,
        REG_HOLD_LEN    = 3'd6,
        REG_MAKEUP      = 3'd7
    } reg_index_t;

    // envelope phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_MAKEUP,
        ST_FINISH
    } ctrl_state_t;

    // configuration register bank
    typedef struct packed {
        logic [THR_BITS-1:0]    threshold_level;
        logic [GFLOOR_BITS-1:0] gain_floor;
        logic [LEN_BITS-1:0]    attack_samples;
        logic [LEN_BITS-1:0]    release_samples;
        logic [STEP_BITS-1:0]   attack_step;
        logic [STEP_BITS-1:0]   release_step;
        logic [LEN_BITS-1:0]    hold_samples;
        logic [MAKEUP_BITS-1:0] makeup_gain;
    } cfg_t;

    // controller commands to the datapath
    typedef struct packed {
        logic env_step;
        logic mul_gain;
        logic mul_makeup;
        logic out_load;
    } cmd_t;

    // length register to countdown width
    function automatic logic [COUNT_BITS-1:0] to_count(input logic [LEN_BITS-1:0] len);
        return COUNT_BITS'(len);
    endfunction

endpackage

`default_nettype wire

/* src/acge_cfg_regs.sv */
// configuration register bank of the compressor gain envelope
// depends on acge_pkg
`default_nettype none

module acge_cfg_regs
    import acge_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write, masking data to the register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_THRESHOLD:    cfg_next.threshold_level = cfg_data[THR_BITS-1:0];
                REG_GAIN_FLOOR:   cfg_next.gain_floor      = cfg_data[GFLOOR_BITS-1:0];
                REG_ATTACK_LEN:   cfg_next.attack_samples  = cfg_data[LEN_BITS-1:0];
                REG_RELEASE_LEN:  cfg_next.release_samples = cfg_data[LEN_BITS-1:0];
                REG_ATTACK_STEP:  cfg_next.attack_step     = cfg_data[STEP_BITS-1:0];
                REG_RELEASE_STEP: cfg_next.release_step    = cfg_data[STEP_BITS-1:0];
                REG_HOLD_LEN:     cfg_next.hold_samples    = cfg_data[LEN_BITS-1:0];
                REG_MAKEUP:       cfg_next.makeup_gain     = cfg_data[MAKEUP_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= RST_THRESHOLD;
            cfg_reg.gain_floor      <= RST_FLOOR;
            cfg_reg.attack_samples  <= RST_ATTACK;
            cfg_reg.release_samples <= RST_RELEASE;
            cfg_reg.attack_step     <= '0;
            cfg_reg.release_step    <= '0;
            cfg_reg.hold_samples    <= '0;
            cfg_reg.makeup_gain     <= RST_MAKEUP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/acge_ctrl.sv */
// sequencing controller of the compressor gain envelope
// depends on acge_pkg
`default_nettype none

module acge_ctrl
    import acge_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    // output register can take a result this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:   state_next = ST_MUL_MAKEUP;
            ST_MUL_MAKEUP: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.env_step = in_valid;
            end
            ST_MUL_GAIN:   cmd.mul_gain   = 1'b1;
            ST_MUL_MAKEUP: cmd.mul_makeup = 1'b1;
            ST_FINISH:     cmd.out_load   = slot_free;
            default:       cmd = '0;
        endcase
    end

    // result valid flag
    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/acge_datapath.sv */
// envelope state, gain and makeup multipliers, clipping and output register
// depends on acge_pkg
`default_nettype none

module acge_datapath
    import acge_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cmd_t                          cmd,
    input  wire cfg_t                          cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               clipped,
    output logic [1:0]                         phase_now
);

    // envelope state
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [GAIN_BITS-1:0]  gain_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    // item pipeline
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   neg_reg;
    logic [P1_BITS-1:0]     p1_reg;
    logic [PA_BITS-1:0]     pa_reg;
    logic [PB_BITS-1:0]     pb_reg;

    // result register
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   clipped_reg;
    phase_t                 phase_out_reg;

    // combinational helpers
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag_c;
    logic                   above;
    logic                   below;
    logic [GAIN_BITS-1:0]   floor_x;
    logic [GAIN_BITS-1:0]   astep_x;
    logic [GAIN_BITS:0]     rsum;
    logic [SUM_BITS-1:0]    sum;
    logic [Q_BITS-1:0]      q;
    logic [Q_BITS-1:0]      limit;
    logic [Q_BITS-1:0]      q_sat;
    logic                   clip_c;
    logic [SAMPLE_BITS-1:0] res_c;

    // magnitude and threshold compare of the incoming sample
    assign raw     = sample_in;
    assign mag_c   = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign above   = CMP_BITS'(mag_c) > CMP_BITS'(cfg.threshold_level);
    assign below   = CMP_BITS'(mag_c) < CMP_BITS'(cfg.threshold_level);
    assign floor_x = GAIN_BITS'(cfg.gain_floor);
    assign astep_x = GAIN_BITS'(cfg.attack_step);
    assign rsum    = (GAIN_BITS+1)'(gain_reg) + (GAIN_BITS+1)'(cfg.release_step);

    // envelope update: engage, release trigger, then phase action
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        gain_next  = gain_reg;

        // engage or re-arm hold
        if (above)
        begin
            if ((gain_reg >= floor_x) && ((phase_reg == PH_IDLE) || (phase_reg == PH_RELEASE)))
            begin
                phase_next = PH_ATTACK;
                count_next = to_count(cfg.attack_samples);
            end
            if (phase_next == PH_HOLD)
            begin
                count_next = to_count(cfg.hold_samples);
            end
        end

        // early release from an expired hold
        if (below && (gain_reg <= GAIN_ONE) && (count_next == '0) && (phase_next == PH_HOLD))
        begin
            phase_next = PH_RELEASE;
            count_next = to_count(cfg.release_samples);
        end

        // phase action
        case (phase_next)
            PH_IDLE:
            begin
                if (gain_reg < GAIN_ONE)
                begin
                    gain_next = GAIN_ONE;
                end
            end
            PH_ATTACK:
            begin
                if ((count_next != '0) && (gain_reg > floor_x))
                begin
                    gain_next  = (gain_reg > astep_x) ? (gain_reg - astep_x) : '0;
                    count_next = count_next - 1'b1;
                end
                else
                begin
                    phase_next = PH_HOLD;
                    count_next = to_count(cfg.hold_samples);
                end
            end
            PH_HOLD:
            begin
                if (count_next != '0)
                begin
                    count_next = count_next - 1'b1;
                end
                else
                begin
                    phase_next = PH_RELEASE;
                    count_next = to_count(cfg.release_samples);
                end
            end
            PH_RELEASE:
            begin
                if ((count_next != '0) && (gain_reg < GAIN_ONE))
                begin
                    count_next = count_next - 1'b1;
                    gain_next  = rsum[GAIN_BITS] ? GAIN_MAX : rsum[GAIN_BITS-1:0];
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // envelope state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_ONE;
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (cmd.env_step)
        begin
            gain_reg  <= gain_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // clip and restore the sign
    assign sum    = SUM_BITS'(pa_reg) + SUM_BITS'(pb_reg[PB_BITS-1:SPLIT]);
    assign q      = sum[SUM_BITS-1:PROD_SHIFT-SPLIT];
    assign limit  = (Q_BITS'(1) << (SAMPLE_BITS - 1)) - Q_BITS'(!neg_reg);
    assign clip_c = q > limit;
    assign q_sat  = clip_c ? limit : q;
    assign res_c  = neg_reg ? SAMPLE_BITS'(~q_sat + 1'b1) : SAMPLE_BITS'(q_sat);

    // multiply pipeline and result register
    always_ff @(posedge clk)
    begin
        if (cmd.env_step)
        begin
            mag_reg <= mag_c;
            neg_reg <= raw[SAMPLE_BITS-1];
        end
        if (cmd.mul_gain)
        begin
            p1_reg <= P1_BITS'(mag_reg) * P1_BITS'(gain_reg);
        end
        if (cmd.mul_makeup)
        begin
            pa_reg <= PA_BITS'(p1_reg[P1_BITS-1:SPLIT]) * PA_BITS'(cfg.makeup_gain);
            pb_reg <= PB_BITS'(p1_reg[SPLIT-1:0]) * PB_BITS'(cfg.makeup_gain);
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= res_c;
            clipped_reg    <= clip_c;
            phase_out_reg  <= phase_reg;
        end
    end

    assign sample_out = signed'(sample_out_reg);
    assign clipped    = clipped_reg;
    assign phase_now  = phase_out_reg;

endmodule

`default_nettype wire

/* src/audio_compressor_gain_envelope.sv */
// channel     handshake            payload
// input       in_valid/in_stall    sample_in
// output      out_valid/out_stall  sample_out, clipped, phase_now
// config      cfg_we               cfg_index, cfg_data
//
// a sample goes through the envelope update on acceptance, |sample| x gain,
// the split makeup multiply, then clip into the output register.
// the two multiplier stages each register a product ahead of the output stage.
// a new sample is taken while the previous result waits in the output register;
// a stalled output holds the finish stage until the register frees.
// reset is asynchronous, active low; envelope state and config registers return to defaults.
//
// top level of the compressor gain envelope
// depends on acge_pkg, acge_cfg_regs, acge_ctrl, acge_datapath and the defines header
`default_nettype none

`include "audio_compressor_gain_envelope_defines.svh"

module audio_compressor_gain_envelope
    import acge_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               clipped,
    output logic [1:0]                         phase_now,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    // configuration registers
    acge_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencing
    acge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // envelope and arithmetic
    acge_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .clipped    (clipped),
        .phase_now  (phase_now)
    );

    // checks on sequencing
    `ACGE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted transaction did not make the block busy")
    `ACGE_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid, "result load did not raise out_valid")
    `ACGE_ASSERT_SAME(a_load_only_busy, cmd.out_load, in_stall && !cmd.env_step, "result load while input side idle")

endmodule

`default_nettype wire

/* tb/sv/gain_envelope_checker.sv */
`timescale 1ns / 100ps
// gain_envelope_checker: watches the sample, result and register ports of the compressor
// gain envelope, predicts every result and compares it field by field; needs acge_pkg
module gain_envelope_checker
    import acge_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          clipped,
    input  logic [1:0]                    phase_now,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   clip;
        phase_t                 env;
    } scaled_sample_t;

    // shadow registers and envelope state
    cfg_t                  regs;
    logic [GAIN_BITS-1:0]  gain_q;
    phase_t                env_phase;
    logic [COUNT_BITS-1:0] count_q;

    scaled_sample_t awaited[$];
    int             errors = 0;
    int             depth = 0;

    assign mismatches  = errors;
    assign outstanding = depth;

    // one envelope step followed by the gain and makeup scaling
    function automatic scaled_sample_t compress_sample(input logic [SAMPLE_BITS-1:0] raw);
        logic                 neg;
        logic [SAMPLE_BITS:0] mag;
        logic [GAIN_BITS:0]   raised;
        logic [63:0]          p1;
        logic [63:0]          hi;
        logic [63:0]          lo;
        logic [63:0]          q;
        logic [63:0]          limit;
        scaled_sample_t       r;
        neg = raw[SAMPLE_BITS-1];
        mag = neg ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};

        // loud sample: engage the attack, or re-arm a running hold
        if (mag > regs.threshold_level)
        begin
            if (gain_q >= regs.gain_floor &&
                (env_phase == PH_IDLE || env_phase == PH_RELEASE))
            begin
                env_phase = PH_ATTACK;
                count_q   = regs.attack_samples;
            end
            if (env_phase == PH_HOLD)
                count_q = regs.hold_samples;
        end

        // quiet sample after an expired hold starts the release
        if (mag < regs.threshold_level && gain_q <= GAIN_ONE &&
            count_q == 0 && env_phase == PH_HOLD)
        begin
            env_phase = PH_RELEASE;
            count_q   = regs.release_samples;
        end

        case (env_phase)
            PH_IDLE:
            begin
                if (gain_q < GAIN_ONE)
                    gain_q = GAIN_ONE;
            end
            PH_ATTACK:
            begin
                if (count_q != 0 && gain_q > regs.gain_floor)
                begin
                    gain_q  = (gain_q > regs.attack_step) ? gain_q - regs.attack_step : '0;
                    count_q = count_q - 1'b1;
                end
                else
                begin
                    env_phase = PH_HOLD;
                    count_q   = regs.hold_samples;
                end
            end
            PH_HOLD:
            begin
                if (count_q != 0)
                    count_q = count_q - 1'b1;
                else
                begin
                    env_phase = PH_RELEASE;
                    count_q   = regs.release_samples;
                end
            end
            default:
            begin
                if (count_q != 0 && gain_q < GAIN_ONE)
                begin
                    count_q = count_q - 1'b1;
                    raised  = {1'b0, gain_q} + regs.release_step;
                    gain_q  = (raised > {1'b0, GAIN_MAX}) ? GAIN_MAX : raised[GAIN_BITS-1:0];
                end
                else
                    env_phase = PH_IDLE;
            end
        endcase

        // |sample| x gain, then the makeup multiply on the split product
        p1 = 64'(mag) * 64'(gain_q);
        hi = p1 >> SPLIT;
        lo = p1 & ((64'd1 << SPLIT) - 1);
        q  = (hi * regs.makeup_gain + ((lo * regs.makeup_gain) >> SPLIT))
             >> (PROD_SHIFT - SPLIT);

        // saturate to the signed sample range
        limit  = neg ? (64'd1 << (SAMPLE_BITS - 1)) : (64'd1 << (SAMPLE_BITS - 1)) - 1;
        r.clip = (q > limit);
        if (r.clip)
            q = limit;
        r.sample = neg ? SAMPLE_BITS'(64'd0 - q) : SAMPLE_BITS'(q);
        r.env    = env_phase;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_sample_t want;
        if (!rst_n)
        begin
            regs.threshold_level = RST_THRESHOLD;
            regs.gain_floor      = RST_FLOOR;
            regs.attack_samples  = RST_ATTACK;
            regs.release_samples = RST_RELEASE;
            regs.attack_step     = '0;
            regs.release_step    = '0;
            regs.hold_samples    = '0;
            regs.makeup_gain     = RST_MAKEUP;
            gain_q    = GAIN_ONE;
            env_phase = PH_IDLE;
            count_q   = '0;
            awaited.delete();
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result transaction with no sample pending: sample_out %0d",
                           sample_out);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.sample), sample_out);
                        errors++;
                    end
                    if (clipped !== want.clip)
                    begin
                        $error("clipped: expected %0d, actual %0d", want.clip, clipped);
                        errors++;
                    end
                    if (phase_now !== want.env)
                    begin
                        $error("phase_now: expected %0d, actual %0d", want.env, phase_now);
                        errors++;
                    end
                end
            end

            // sample transaction feeds the prediction
            if (in_valid && !in_stall)
                awaited.push_back(compress_sample(sample_in));

            // register writes, masked to each register's width
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_THRESHOLD:    regs.threshold_level = cfg_data[THR_BITS-1:0];
                    REG_GAIN_FLOOR:   regs.gain_floor      = cfg_data[GFLOOR_BITS-1:0];
                    REG_ATTACK_LEN:   regs.attack_samples  = cfg_data[LEN_BITS-1:0];
                    REG_RELEASE_LEN:  regs.release_samples = cfg_data[LEN_BITS-1:0];
                    REG_ATTACK_STEP:  regs.attack_step     = cfg_data[STEP_BITS-1:0];
                    REG_RELEASE_STEP: regs.release_step    = cfg_data[STEP_BITS-1:0];
                    REG_HOLD_LEN:     regs.hold_samples    = cfg_data[LEN_BITS-1:0];
                    default:          regs.makeup_gain     = cfg_data[MAKEUP_BITS-1:0];
                endcase
            end
        end
        depth = awaited.size();
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// tb: drives samples and register settings into the compressor gain envelope and
// gives the verdict; needs acge_pkg, gain_envelope_checker and the block itself
module tb;
    import acge_pkg::*;

    localparam int UNITY           = 1 << 24;
    localparam int PRESSURE_CYCLES = 80;
    localparam int QUIET_LIMIT     = 1000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
    logic [1:0]                    phase_now;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    int                            mismatches;
    int                            outstanding;

    int send_idle_pct  = 18;
    int recv_stall_pct = 83;
    int thr_now        = 32767;
    int loud_left      = 0;
    int quiet_left     = 0;
    int idle_cycles    = 0;
    bit hold_off_req   = 0;
    bit hold_off_done  = 0;

    audio_compressor_gain_envelope uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .clipped    (clipped),
        .phase_now  (phase_now),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    gain_envelope_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .clipped     (clipped),
        .phase_now   (phase_now),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure, with one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_stall = 1'b1;
                repeat (PRESSURE_CYCLES - 1) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else
                out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction or register write
    initial
    begin
        while (idle_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("audio_compressor_gain_envelope verification failed");
        $finish;
    end

    // one register write, sometimes with junk above the register's width
    task automatic write_reg(input reg_index_t idx, input int value);
        logic [CFG_DATA_BITS-1:0] keep;
        logic [CFG_DATA_BITS-1:0] data;
        case (idx)
            REG_THRESHOLD: keep = CFG_DATA_BITS'((1 << THR_BITS) - 1);
            REG_MAKEUP:    keep = CFG_DATA_BITS'((1 << MAKEUP_BITS) - 1);
            REG_GAIN_FLOOR, REG_ATTACK_STEP, REG_RELEASE_STEP: keep = '1;
            default:       keep = CFG_DATA_BITS'((1 << LEN_BITS) - 1);
        endcase
        data = CFG_DATA_BITS'(value);
        if ($urandom_range(3) == 0)
            data = data | (CFG_DATA_BITS'($urandom) & ~keep);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
    endtask

    task automatic write_settings(input int thr, input int floor_v, input int att,
                                  input int rel, input int astep, input int rstep,
                                  input int hold, input int mk);
        thr_now    = thr;
        loud_left  = 0;
        quiet_left = 0;
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_GAIN_FLOOR, floor_v);
        write_reg(REG_ATTACK_LEN, att);
        write_reg(REG_RELEASE_LEN, rel);
        write_reg(REG_ATTACK_STEP, astep);
        write_reg(REG_RELEASE_STEP, rstep);
        write_reg(REG_HOLD_LEN, hold);
        write_reg(REG_MAKEUP, mk);
        cfg_we = 1'b0;
    endtask

    // lowest, highest or a random envelope with short lengths
    task automatic pick_settings(input int style);
        int floor_v;
        int att;
        int rel;
        int astep;
        int rstep;
        if (style == 0)
            write_settings(0, 0, 1, 1, 0, 0, 0, 0);
        else if (style == 1)
            write_settings(32767, UNITY, 1048575, 1048575, UNITY, UNITY, 1048575, 65535);
        else
        begin
            floor_v = $urandom_range(UNITY, 0);
            att     = $urandom_range(12, 1);
            rel     = $urandom_range(24, 1);
            astep   = (UNITY - floor_v) / att + $urandom_range(20000, 0);
            rstep   = (UNITY - floor_v) / rel + $urandom_range(4000000, 0);
            if (astep > UNITY)
                astep = UNITY;
            if (rstep > UNITY)
                rstep = UNITY;
            write_settings($urandom_range(32767, 0), floor_v, att, rel, astep, rstep,
                           $urandom_range(6, 0),
                           $urandom_range(1) ? 4096 : $urandom_range(65535, 0));
        end
    endtask

    // bursts of loud samples followed by quiet stretches, with some noise
    function automatic logic [SAMPLE_BITS-1:0] next_sample();
        int mag;
        int pick;
        pick = $urandom_range(99);
        if (loud_left == 0 && quiet_left == 0)
        begin
            loud_left  = $urandom_range(10, 1);
            quiet_left = $urandom_range(40, 1);
        end
        if (pick < 15)
            return SAMPLE_BITS'($urandom);
        if (pick < 20)
            mag = thr_now;
        else if (loud_left > 0)
        begin
            loud_left--;
            mag = $urandom_range(32768, thr_now + 1);
        end
        else
        begin
            quiet_left--;
            mag = (thr_now == 0) ? 0 : $urandom_range(thr_now - 1, 0);
        end
        if (mag == 32768 || $urandom_range(1))
            return SAMPLE_BITS'(-mag);
        return SAMPLE_BITS'(mag);
    endfunction

    // offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        sample_in = value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain all pending results, then let the pipeline empty
    task automatic settle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: zero, threshold-equal magnitude, most negative sample
        send_sample(16'd0);
        send_sample(16'd32767);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        send_sample(16'd32767);
        settle();

        // attack underflows the gain, release overshoots unity, full makeup clips
        write_settings(1000, 0, 3, 4, 12000000, 10000000, 1, 65535);
        send_sample(16'd1000);
        send_sample(16'd20000);
        send_sample(-16'sd20000);
        repeat (5) send_sample(16'd5);
        send_sample(16'd32767);
        send_sample(16'h8000);
        settle();

        // zero attack length ends the attack on its first step
        write_settings(100, 8388608, 0, 1, 4194304, 0, 0, 4096);
        send_sample(16'd200);
        send_sample(-16'sd50);
        send_sample(16'd50);
        send_sample(-16'sd100);
        settle();

        // random phases: sender idles lightly, then heavily, then not at all
        for (int k = 0; k < 9; k++)
        begin
            send_idle_pct  = (k < 3) ? 18 : (k < 6) ? 83 : 0;
            recv_stall_pct = (k < 3) ? 83 : (k < 6) ? 18 : 0;
            pick_settings((k == 0) ? 0 : (k == 4) ? 1 : 2);
            if (k == 1)
                hold_off_req = 1'b1;
            repeat (76) send_sample(next_sample());
            settle();
        end

        if (mismatches == 0)
            $display("audio_compressor_gain_envelope verification clean");
        else
            $display("audio_compressor_gain_envelope verification failed");
        $finish;
    end

endmodule
